>>> hdl/qvr_pkg.sv
package qvr_pkg;

   localparam int QUAT_W = 16;
   localparam int VEC_W  = 24;
   localparam int PP_W   = 2 * QUAT_W;
   localparam int MAT_W  = PP_W + 3;
   localparam int NORM_W = PP_W + 1;
   localparam int PROD_W = MAT_W + VEC_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int REM_W  = SUM_W;
   localparam int DEN_W  = NORM_W + 1;
   localparam int DIV_N  = VEC_W;

   localparam logic [VEC_W-1:0] POS_LIMIT = {1'b0, {(VEC_W-1){1'b1}}};
   localparam logic [VEC_W-1:0] NEG_LIMIT = {1'b1, {(VEC_W-1){1'b0}}};

endpackage

>>> hdl/quaternion_vector_rotate_core.sv
// Rotates a signed 24-bit vector by a Q2.14 quaternion, dividing by the squared norm so the
// quaternion need not be unit length; each component is rounded to nearest (ties away from
// zero) and saturated. The core is a fixed pipeline of 30 register stages: a beat taken at
// one edge has its result on the rsp_ ports, with rsp_valid high, for the one cycle
// once it has passed through all stages. A new beat can be taken in every cycle, so busy
// stays low, and the receiver cannot hold results off, so it must take every rsp_valid
// beat as it comes. Four stages form the quaternion products, the rotation matrix and
// norm, the matrix-vector products and their sums; a fifth forms the rounding numerator
// and the overflow check; 24 restoring divider stages then give one quotient bit each
// for all three components in parallel, and a last stage registers the saturated result.
// A zero quaternion gives a zero vector with rsp_zero_quat set.
module quaternion_vector_rotate_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [qvr_pkg::QUAT_W-1:0]   req_quat_x,
   input  logic signed [qvr_pkg::QUAT_W-1:0]   req_quat_y,
   input  logic signed [qvr_pkg::QUAT_W-1:0]   req_quat_z,
   input  logic signed [qvr_pkg::QUAT_W-1:0]   req_quat_w,
   input  logic signed [qvr_pkg::VEC_W-1:0]    req_vec_x,
   input  logic signed [qvr_pkg::VEC_W-1:0]    req_vec_y,
   input  logic signed [qvr_pkg::VEC_W-1:0]    req_vec_z,
   output logic                                rsp_valid,
   output logic signed [qvr_pkg::VEC_W-1:0]    rsp_rot_x,
   output logic signed [qvr_pkg::VEC_W-1:0]    rsp_rot_y,
   output logic signed [qvr_pkg::VEC_W-1:0]    rsp_rot_z,
   output logic                                rsp_zero_quat,
   output logic                                rsp_saturated
);

   localparam int PW = qvr_pkg::PP_W;
   localparam int MW = qvr_pkg::MAT_W;
   localparam int NW = qvr_pkg::NORM_W;
   localparam int VW = qvr_pkg::VEC_W;
   localparam int RW = qvr_pkg::REM_W;
   localparam int SW = qvr_pkg::SUM_W;
   localparam int DW = qvr_pkg::DEN_W;
   localparam int DN = qvr_pkg::DIV_N;

   assign busy = 1'b0;

   // Stage 1: quaternion products.
   logic                 v1_ff;
   logic signed [PW-1:0] ww_ff, xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic signed [VW-1:0] vec1_ff [0:2];

   // Stage 2: rotation matrix and norm.
   logic                 v2_ff;
   logic signed [MW-1:0] mat_ff [0:2][0:2];
   logic signed [MW-1:0] mat_in [0:2][0:2];
   logic [NW-1:0]        norm2_ff, norm2_in;
   logic signed [VW-1:0] vec2_ff [0:2];

   // Stage 3: matrix-vector products.
   logic                                  v3_ff;
   logic signed [qvr_pkg::PROD_W-1:0]     prod_ff [0:2][0:2];
   logic [NW-1:0]                         norm3_ff;

   // Stage 4: row sums.
   logic                 v4_ff;
   logic signed [SW-1:0] sum_ff [0:2];
   logic [NW-1:0]        norm4_ff;

   // Divider stages: index 0 is loaded from the row sums.
   logic          dv_ff   [0:DN];
   logic          zero_ff [0:DN];
   logic [DW-1:0] den_ff  [0:DN];
   logic [2:0]    neg_ff  [0:DN];
   logic [2:0]    ovf_ff  [0:DN];
   logic [RW-1:0] rem_ff  [0:DN][0:2];
   logic [VW-1:0] quo_ff  [0:DN][0:2];
   logic [RW-1:0] rem_in  [0:DN][0:2];
   logic [VW-1:0] quo_in  [0:DN][0:2];
   logic [2:0]    neg_in, ovf_in;
   logic [DW-1:0] den_in;

   logic [VW-1:0] rot_in [0:2];
   logic [2:0]    sat_in;

   always_comb begin
      norm2_in = NW'(ww_ff[PW-2:0]) + NW'(xx_ff[PW-2:0]) + NW'(yy_ff[PW-2:0])
               + NW'(zz_ff[PW-2:0]);
      mat_in[0][0] = MW'(ww_ff) + MW'(xx_ff) - MW'(yy_ff) - MW'(zz_ff);
      mat_in[0][1] = (MW'(xy_ff) - MW'(wz_ff)) <<< 1;
      mat_in[0][2] = (MW'(xz_ff) + MW'(wy_ff)) <<< 1;
      mat_in[1][0] = (MW'(xy_ff) + MW'(wz_ff)) <<< 1;
      mat_in[1][1] = MW'(ww_ff) - MW'(xx_ff) + MW'(yy_ff) - MW'(zz_ff);
      mat_in[1][2] = (MW'(yz_ff) - MW'(wx_ff)) <<< 1;
      mat_in[2][0] = (MW'(xz_ff) - MW'(wy_ff)) <<< 1;
      mat_in[2][1] = (MW'(yz_ff) + MW'(wx_ff)) <<< 1;
      mat_in[2][2] = MW'(ww_ff) - MW'(xx_ff) - MW'(yy_ff) + MW'(zz_ff);
   end

   // The rounded quotient of m by n equals floor((2m + n) / 2n), so the divider works on
   // that numerator and needs no correction at the end.
   always_comb begin
      den_in = {norm4_ff, 1'b0};
      for (int r = 0; r < 3; r++) begin
         logic [SW-1:0] mag;
         mag = sum_ff[r][SW-1] ? SW'(-sum_ff[r]) : SW'(sum_ff[r]);
         neg_in[r] = sum_ff[r][SW-1];
         rem_in[0][r] = RW'({mag[SW-2:0], 1'b0}) + RW'(norm4_ff);
         quo_in[0][r] = '0;
         ovf_in[r] = rem_in[0][r] >= (RW'(den_in) << DN);
      end
      for (int s = 0; s < DN; s++) begin
         for (int r = 0; r < 3; r++) begin
            logic [RW-1:0] trial;
            trial = RW'(den_ff[s]) << (DN - 1 - s);
            if (rem_ff[s][r] >= trial) begin
               rem_in[s+1][r] = rem_ff[s][r] - trial;
               quo_in[s+1][r] = quo_ff[s][r] | (VW'(1) << (DN - 1 - s));
            end else begin
               rem_in[s+1][r] = rem_ff[s][r];
               quo_in[s+1][r] = quo_ff[s][r];
            end
         end
      end
      for (int r = 0; r < 3; r++) begin
         logic [VW-1:0] lim, mag_q;
         lim = neg_ff[DN][r] ? qvr_pkg::NEG_LIMIT : qvr_pkg::POS_LIMIT;
         sat_in[r] = ovf_ff[DN][r] || (quo_ff[DN][r] > lim);
         mag_q = sat_in[r] ? lim : quo_ff[DN][r];
         rot_in[r] = zero_ff[DN] ? '0 : (neg_ff[DN][r] ? VW'(-mag_q) : mag_q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         for (int s = 0; s <= DN; s++) begin
            dv_ff[s] <= 1'b0;
         end
         rsp_valid <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         dv_ff[0] <= v4_ff;
         for (int s = 0; s < DN; s++) begin
            dv_ff[s+1] <= dv_ff[s];
         end
         rsp_valid <= dv_ff[DN];
      end

      ww_ff <= req_quat_w * req_quat_w;
      xx_ff <= req_quat_x * req_quat_x;
      yy_ff <= req_quat_y * req_quat_y;
      zz_ff <= req_quat_z * req_quat_z;
      xy_ff <= req_quat_x * req_quat_y;
      xz_ff <= req_quat_x * req_quat_z;
      yz_ff <= req_quat_y * req_quat_z;
      wx_ff <= req_quat_w * req_quat_x;
      wy_ff <= req_quat_w * req_quat_y;
      wz_ff <= req_quat_w * req_quat_z;
      vec1_ff[0] <= req_vec_x;
      vec1_ff[1] <= req_vec_y;
      vec1_ff[2] <= req_vec_z;

      mat_ff   <= mat_in;
      norm2_ff <= norm2_in;
      vec2_ff  <= vec1_ff;

      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_ff[r][c] <= mat_ff[r][c] * vec2_ff[c];
         end
      end
      norm3_ff <= norm2_ff;

      for (int r = 0; r < 3; r++) begin
         sum_ff[r] <= SW'(prod_ff[r][0]) + SW'(prod_ff[r][1]) + SW'(prod_ff[r][2]);
      end
      norm4_ff <= norm3_ff;

      zero_ff[0] <= norm4_ff == '0;
      den_ff[0]  <= den_in;
      neg_ff[0]  <= neg_in;
      ovf_ff[0]  <= ovf_in;
      for (int r = 0; r < 3; r++) begin
         rem_ff[0][r] <= rem_in[0][r];
         quo_ff[0][r] <= quo_in[0][r];
      end
      for (int s = 0; s < DN; s++) begin
         zero_ff[s+1] <= zero_ff[s];
         den_ff[s+1]  <= den_ff[s];
         neg_ff[s+1]  <= neg_ff[s];
         ovf_ff[s+1]  <= ovf_ff[s];
         for (int r = 0; r < 3; r++) begin
            rem_ff[s+1][r] <= rem_in[s+1][r];
            quo_ff[s+1][r] <= quo_in[s+1][r];
         end
      end

      rsp_rot_x     <= rot_in[0];
      rsp_rot_y     <= rot_in[1];
      rsp_rot_z     <= rot_in[2];
      rsp_zero_quat <= zero_ff[DN];
      rsp_saturated <= !zero_ff[DN] && (sat_in != 3'b000);
   end

`ifndef ASSERT_OFF
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_quat |-> rsp_rot_x == '0 && rsp_rot_y == '0 && rsp_rot_z == '0)
      else $error("zero quaternion beat with nonzero vector");

   a_zero_nosat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_zero_quat && rsp_saturated))
      else $error("zero quaternion beat flagged as saturated");

   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_rot_x == qvr_pkg::POS_LIMIT || rsp_rot_x == qvr_pkg::NEG_LIMIT ||
         rsp_rot_y == qvr_pkg::POS_LIMIT || rsp_rot_y == qvr_pkg::NEG_LIMIT ||
         rsp_rot_z == qvr_pkg::POS_LIMIT || rsp_rot_z == qvr_pkg::NEG_LIMIT)
      else $error("saturated beat without a clamped component");
`endif

endmodule

>>> tb/tb_quaternion_vector_rotate_core.sv
`timescale 1ns / 1ps

module tb_quaternion_vector_rotate_core;

   localparam int QW = qvr_pkg::QUAT_W;
   localparam int VW = qvr_pkg::VEC_W;

   typedef struct {
      logic signed [QW-1:0] qx, qy, qz, qw;
      logic signed [VW-1:0] vx, vy, vz;
      int unsigned          gap_pct;
      bit                   drain;
   } rot_req_type;

   typedef struct {
      logic signed [VW-1:0] rx, ry, rz;
      logic                 zero_q;
      logic                 sat;
   } rot_rsp_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [QW-1:0] req_quat_x, req_quat_y, req_quat_z, req_quat_w;
   logic signed [VW-1:0] req_vec_x, req_vec_y, req_vec_z;
   logic rsp_valid;
   logic signed [VW-1:0] rsp_rot_x, rsp_rot_y, rsp_rot_z;
   logic rsp_zero_quat, rsp_saturated;

   rot_req_type pending_q[$];
   rot_rsp_type rotation_q[$];
   rot_req_type cur_beat;
   int          mismatches = 0;

   quaternion_vector_rotate_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_quat_x(req_quat_x), .req_quat_y(req_quat_y),
      .req_quat_z(req_quat_z), .req_quat_w(req_quat_w),
      .req_vec_x(req_vec_x), .req_vec_y(req_vec_y), .req_vec_z(req_vec_z),
      .rsp_valid(rsp_valid), .rsp_rot_x(rsp_rot_x), .rsp_rot_y(rsp_rot_y),
      .rsp_rot_z(rsp_rot_z), .rsp_zero_quat(rsp_zero_quat),
      .rsp_saturated(rsp_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic signed [VW-1:0] rotate_component(longint a, longint b,
         longint c, longint vx, longint vy, longint vz, longint norm, ref logic sat);
      logic signed [127:0] acc;
      logic signed [127:0] t1;
      logic signed [127:0] t2;
      logic [127:0] mag, quo, rem, den, lim;
      logic neg;
      t1 = a; t2 = vx; acc = t1 * t2;
      t1 = b; t2 = vy; acc = acc + t1 * t2;
      t1 = c; t2 = vz; acc = acc + t1 * t2;
      neg = acc < 0;
      mag = neg ? -acc : acc;
      den = norm;
      quo = mag / den;
      rem = mag % den;
      if (rem >= den - rem) quo = quo + 1;
      lim = neg ? (128'd1 << (VW - 1)) : (128'd1 << (VW - 1)) - 1;
      if (quo > lim) begin
         quo = lim;
         sat = 1'b1;
      end
      return neg ? -quo[VW-1:0] : quo[VW-1:0];
   endfunction

   function automatic rot_rsp_type predict_rotation(rot_req_type r);
      longint x, y, z, w, vx, vy, vz, ww, xx, yy, zz, xy, xz, yz, wx, wy, wz, norm;
      rot_rsp_type e;
      logic sat;
      x = r.qx; y = r.qy; z = r.qz; w = r.qw;
      vx = r.vx; vy = r.vy; vz = r.vz;
      ww = w * w; xx = x * x; yy = y * y; zz = z * z;
      xy = x * y; xz = x * z; yz = y * z; wx = w * x; wy = w * y; wz = w * z;
      norm = ww + xx + yy + zz;
      sat = 1'b0;
      e.zero_q = 1'b0;
      if (norm == 0) begin
         e.rx = '0; e.ry = '0; e.rz = '0; e.zero_q = 1'b1; e.sat = 1'b0;
         return e;
      end
      e.rx = rotate_component(ww + xx - yy - zz, 2 * (xy - wz), 2 * (xz + wy),
                              vx, vy, vz, norm, sat);
      e.ry = rotate_component(2 * (xy + wz), ww - xx + yy - zz, 2 * (yz - wx),
                              vx, vy, vz, norm, sat);
      e.rz = rotate_component(2 * (xz - wy), 2 * (yz + wx), ww - xx - yy + zz,
                              vx, vy, vz, norm, sat);
      e.sat = sat;
      return e;
   endfunction

   // The driver holds a beat while busy and may pause for a full drain before some beats.
   always @(posedge clock) begin
      rot_req_type nxt;
      bit take;
      if (reset) begin
         start <= 1'b0;
         req_quat_x <= '0; req_quat_y <= '0; req_quat_z <= '0; req_quat_w <= '0;
         req_vec_x <= '0; req_vec_y <= '0; req_vec_z <= '0;
      end else if (!(start && busy)) begin
         if (start) rotation_q.push_back(predict_rotation(cur_beat));
         take = 0;
         if (pending_q.size() > 0) begin
            nxt = pending_q[0];
            take = $urandom_range(99) >= nxt.gap_pct;
            if (nxt.drain && (rotation_q.size() != 0 || start)) take = 0;
         end
         if (take) begin
            void'(pending_q.pop_front());
            cur_beat <= nxt;
            req_quat_x <= nxt.qx; req_quat_y <= nxt.qy;
            req_quat_z <= nxt.qz; req_quat_w <= nxt.qw;
            req_vec_x <= nxt.vx; req_vec_y <= nxt.vy; req_vec_z <= nxt.vz;
         end
         start <= take;
      end
   end

   always @(posedge clock) begin
      rot_rsp_type e;
      if (!reset && rsp_valid) begin
         if (rotation_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result beat: %0d %0d %0d",
                                           rsp_rot_x, rsp_rot_y, rsp_rot_z);
         end else begin
            e = rotation_q.pop_front();
            if (rsp_rot_x !== e.rx || rsp_rot_y !== e.ry || rsp_rot_z !== e.rz ||
                rsp_zero_quat !== e.zero_q || rsp_saturated !== e.sat) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %0d %0d %0d z%0b s%0b, got %0d %0d %0d z%0b s%0b",
                           e.rx, e.ry, e.rz, e.zero_q, e.sat, rsp_rot_x, rsp_rot_y,
                           rsp_rot_z, rsp_zero_quat, rsp_saturated);
            end
         end
      end
   end

   function automatic rot_req_type make_beat(int qx, int qy, int qz, int qw,
                                             int vx, int vy, int vz);
      rot_req_type r;
      r.qx = QW'(qx); r.qy = QW'(qy); r.qz = QW'(qz); r.qw = QW'(qw);
      r.vx = VW'(vx); r.vy = VW'(vy); r.vz = VW'(vz);
      r.gap_pct = 20;
      r.drain = 0;
      return r;
   endfunction

   function automatic logic signed [QW-1:0] rand_quat();
      case ($urandom_range(9))
         0: return QW'($urandom_range(8)) - QW'(4);
         1: return '0;
         default: return QW'($urandom);
      endcase
   endfunction

   initial begin
      rot_req_type r;
      int unsigned i;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      pending_q.push_back(make_beat(0, 0, 0, 0, 8388607, -8388608, 5));
      pending_q.push_back(make_beat(0, 0, 0, 16384, 8388607, -8388608, 0));
      pending_q.push_back(make_beat(0, 0, 0, -16384, -1, 1, -8388608));
      pending_q.push_back(make_beat(1, 0, 0, 0, 8388607, 8388607, -8388608));
      pending_q.push_back(make_beat(-32768, -32768, -32768, -32768, 8388607, 3, -7));
      pending_q.push_back(make_beat(32767, 32767, 32767, 32767, -8388608, 8388607, 1));
      pending_q.push_back(make_beat(0, 0, 6270, 15137, 8388607, 8388607, 0));
      pending_q.push_back(make_beat(0, 0, 6270, 15137, -8388608, -8388608, 0));
      pending_q.push_back(make_beat(0, 6270, 0, 15137, 8388607, 0, 8388607));
      pending_q.push_back(make_beat(6270, 0, 0, 15137, 0, -8388608, -8388608));
      pending_q.push_back(make_beat(16384, 0, 0, 0, 123, -456, 789));
      pending_q.push_back(make_beat(0, 16384, 0, 0, 123, -456, 789));
      pending_q.push_back(make_beat(0, 0, 16384, 0, 123, -456, 789));
      pending_q.push_back(make_beat(1, 1, 0, 0, 1, 0, 1));
      pending_q.push_back(make_beat(1, 1, 1, 1, 1, 2, 3));
      pending_q.push_back(make_beat(0, 0, 0, 3, 7, -7, 1));
      r = make_beat(0, 0, 1, 1, 3, -3, 5);
      r.drain = 1;
      pending_q.push_back(r);

      for (i = 0; i < 1000; i++) begin
         r.qx = rand_quat(); r.qy = rand_quat(); r.qz = rand_quat(); r.qw = rand_quat();
         if ($urandom_range(3) == 0) begin
            r.vx = VW'($urandom_range(16)) - VW'(8);
            r.vy = VW'($urandom_range(16)) - VW'(8);
            r.vz = VW'($urandom_range(16)) - VW'(8);
         end else begin
            r.vx = VW'($urandom); r.vy = VW'($urandom); r.vz = VW'($urandom);
         end
         r.gap_pct = (i < 350) ? 20 : (i < 700) ? 83 : 0;
         r.drain = (i == 350 || i == 700 || $urandom_range(199) == 0);
         pending_q.push_back(r);
      end

      wait (pending_q.size() == 0 && !start && rotation_q.size() == 0);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && rotation_q.size() == 0)
         $display("[quaternion_vector_rotate_core] OK");
      else
         $display("[quaternion_vector_rotate_core] ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("[quaternion_vector_rotate_core] ERROR");
      $finish;
   end

endmodule
